>>> hw/rtl/tttr_record_decoder_defines.svh
// assertion macros shared by the time-tag record decoder
`ifndef TTTR_RECORD_DECODER_DEFINES_SVH
`define TTTR_RECORD_DECODER_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define TTTR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// same-cycle implication
`define TTTR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTTR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tttr_pkg.sv
// types and constants of the time-tag record decoder
package tttr_pkg;

    // record layouts
    typedef enum logic [2:0] {
        FMT_PH_T2    = 3'd0,
        FMT_PH_T3    = 3'd1,
        FMT_HH_T2_V1 = 3'd2,
        FMT_HH_T3_V1 = 3'd3,
        FMT_T2_V2    = 3'd4,
        FMT_T3_V2    = 3'd5
    } fmt_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_FORMAT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RES_PS    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_RES_PS   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PERIOD_PS = 4'd3;

    // overflow increments
    localparam int AMT_W = 50;
    localparam logic [AMT_W-1:0] WRAP_PH_T2    = 50'd210698240;
    localparam logic [AMT_W-1:0] WRAP_PH_T3    = 50'd65536;
    localparam logic [AMT_W-1:0] WRAP_HH_T2_V1 = 50'd33552000;
    localparam logic [AMT_W-1:0] WRAP_HH_T2_V2 = 50'd33554432;
    localparam logic [AMT_W-1:0] WRAP_HH_T3    = 50'd1024;

    // channel codes
    localparam logic [7:0] MARK_BASE      = 8'd16;
    localparam logic [3:0] PH_CH_SPECIAL  = 4'hF;
    localparam logic [3:0] PH_T2_MAX_CHAN = 4'd4;
    localparam logic [5:0] HH_CH_WRAP     = 6'h3F;
    localparam logic [5:0] HH_MARK_MAX    = 6'd15;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one decoded event waiting for its time product
    typedef struct packed {
        logic [63:0] base;
        logic [14:0] dtime;
        logic [7:0]  chan;
        logic        is_t3;
    } entry_t;

    // front status
    typedef struct packed {
        logic push;
        logic wrap;
    } front_stat_t;

    // queue status
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_stat_t;

    // resolutions used by the back
    typedef struct packed {
        logic [15:0] tick_res_ps;
        logic [15:0] delay_res_ps;
        logic [31:0] sync_period_ps;
    } res_cfg_t;

endpackage

>>> hw/rtl/tttr_front.sv
// front: accepts records, decodes the layout and tracks the overflow offset
module tttr_front #(
    parameter int OFFSET_WIDTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [2:0]           fmt,
    input  logic                 rec_valid,
    input  logic [31:0]          rec_word,
    input  tttr_pkg::queue_stat_t q_stat,
    output logic                 rec_ready,
    output tttr_pkg::entry_t     entry,
    output tttr_pkg::front_stat_t stat
);

    logic [OFFSET_WIDTH-1:0]    offset_reg;
    logic                       accept;
    logic                       emit;
    logic                       wrap;
    logic [27:0]                count;
    logic [14:0]                dtime;
    logic [7:0]                 chan;
    logic                       is_t3;
    logic [tttr_pkg::AMT_W-1:0] amount;
    logic [3:0]                 ph_ch;
    logic [5:0]                 hh_ch;
    logic                       hh_special;
    logic [24:0]                hh_tag;
    logic [9:0]                 hh_ns;
    logic                       v1;

    // field slices
    assign ph_ch      = rec_word[31:28];
    assign hh_ch      = rec_word[30:25];
    assign hh_special = rec_word[31];
    assign hh_tag     = rec_word[24:0];
    assign hh_ns      = rec_word[9:0];
    assign v1         = (fmt == tttr_pkg::FMT_HH_T2_V1) || (fmt == tttr_pkg::FMT_HH_T3_V1);

    // record classification
    always_comb
    begin
        emit   = 1'b0;
        wrap   = 1'b0;
        count  = '0;
        dtime  = '0;
        chan   = '0;
        is_t3  = 1'b0;
        amount = '0;
        unique case (fmt)
            tttr_pkg::FMT_PH_T2:
            begin
                count = rec_word[27:0];
                priority if (ph_ch == tttr_pkg::PH_CH_SPECIAL)
                begin
                    if (rec_word[3:0] == 4'd0)
                    begin
                        wrap   = 1'b1;
                        amount = tttr_pkg::WRAP_PH_T2;
                    end
                    else
                    begin
                        emit = 1'b1;
                        chan = tttr_pkg::MARK_BASE + {4'b0, rec_word[3:0]};
                    end
                end
                else if (ph_ch <= tttr_pkg::PH_T2_MAX_CHAN)
                begin
                    emit = 1'b1;
                    chan = {4'b0, ph_ch};
                end
                else
                begin
                    emit = 1'b0;
                end
            end
            tttr_pkg::FMT_PH_T3:
            begin
                is_t3 = 1'b1;
                count = {12'b0, rec_word[15:0]};
                if (ph_ch == tttr_pkg::PH_CH_SPECIAL)
                begin
                    if (rec_word[27:16] == 12'd0)
                    begin
                        wrap   = 1'b1;
                        amount = tttr_pkg::WRAP_PH_T3;
                    end
                    else
                    begin
                        emit = 1'b1;
                        chan = tttr_pkg::MARK_BASE + rec_word[23:16];
                    end
                end
                else
                begin
                    emit  = 1'b1;
                    dtime = {3'b0, rec_word[27:16]};
                    chan  = {4'b0, ph_ch};
                end
            end
            tttr_pkg::FMT_HH_T2_V1, tttr_pkg::FMT_T2_V2:
            begin
                count = {3'b0, hh_tag};
                if (hh_special)
                begin
                    priority if (hh_ch == tttr_pkg::HH_CH_WRAP)
                    begin
                        wrap = 1'b1;
                        priority if (v1)
                            amount = tttr_pkg::WRAP_HH_T2_V1;
                        else if (hh_tag == 25'd0)
                            amount = tttr_pkg::WRAP_HH_T2_V2;
                        else
                            amount = {hh_tag, 25'b0};
                    end
                    else if (hh_ch == 6'd0)
                    begin
                        emit = 1'b1;
                        chan = 8'd0;
                    end
                    else if (hh_ch <= tttr_pkg::HH_MARK_MAX)
                    begin
                        emit = 1'b1;
                        chan = tttr_pkg::MARK_BASE + {2'b0, hh_ch};
                    end
                    else
                    begin
                        emit = 1'b0;
                    end
                end
                else
                begin
                    emit = 1'b1;
                    chan = {2'b0, hh_ch} + 8'd1;
                end
            end
            tttr_pkg::FMT_HH_T3_V1, tttr_pkg::FMT_T3_V2:
            begin
                is_t3 = 1'b1;
                count = {18'b0, hh_ns};
                if (hh_special)
                begin
                    priority if (hh_ch == tttr_pkg::HH_CH_WRAP)
                    begin
                        wrap = 1'b1;
                        if (v1 || (hh_ns == 10'd0))
                            amount = tttr_pkg::WRAP_HH_T3;
                        else
                            amount = tttr_pkg::AMT_W'({hh_ns, 10'b0});
                    end
                    else if ((hh_ch != 6'd0) && (hh_ch <= tttr_pkg::HH_MARK_MAX))
                    begin
                        emit = 1'b1;
                        chan = tttr_pkg::MARK_BASE + {2'b0, hh_ch};
                    end
                    else
                    begin
                        emit = 1'b0;
                    end
                end
                else
                begin
                    emit  = 1'b1;
                    dtime = rec_word[24:10];
                    chan  = {2'b0, hh_ch};
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // handshake and queue write
    assign rec_ready   = !q_stat.full;
    assign accept      = rec_valid && rec_ready;
    assign stat.push   = accept && emit;
    assign stat.wrap   = accept && wrap;
    assign entry.base  = 64'(offset_reg) + 64'(count);
    assign entry.dtime = dtime;
    assign entry.chan  = chan;
    assign entry.is_t3 = is_t3;

    // overflow offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else if (stat.wrap)
            offset_reg <= offset_reg + OFFSET_WIDTH'(amount);
    end

endmodule

>>> hw/rtl/tttr_queue.sv
// short queue of decoded events between front and back
module tttr_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tttr_pkg::entry_t      wr_entry,
    input  logic                  pop,
    output tttr_pkg::entry_t      rd_entry,
    output tttr_pkg::queue_stat_t stat
);

    tttr_pkg::entry_t                  slots_reg [tttr_pkg::QUEUE_DEPTH];
    logic [tttr_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [tttr_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [tttr_pkg::QCNT_W-1:0]       count_reg;
    logic                              do_push;
    logic                              do_pop;

    // status
    assign stat.count = count_reg;
    assign stat.full  = (count_reg == tttr_pkg::QCNT_W'(tttr_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_entry   = slots_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

>>> hw/rtl/tttr_back.sv
// back: multiplies the event counts by the resolutions and holds the result
module tttr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tttr_pkg::res_cfg_t  res_cfg,
    input  logic                entry_valid,
    input  tttr_pkg::entry_t    entry,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_ready,
    output logic signed [63:0]  res_time,
    output logic [7:0]          res_chan
);

    logic        s1_valid_reg;
    logic [63:0] s1_lo_reg;
    logic [31:0] s1_hi_reg;
    logic [30:0] s1_dt_reg;
    logic [7:0]  s1_chan_reg;
    logic        s2_valid_reg;
    logic [63:0] s2_sum_reg;
    logic [31:0] s2_hi_reg;
    logic [7:0]  s2_chan_reg;
    logic        out_valid_reg;
    logic [63:0] out_time_reg;
    logic [7:0]  out_chan_reg;

    logic [31:0] mult;
    logic [63:0] s1_lo_next;
    logic [31:0] s1_hi_next;
    logic [30:0] s1_dt_next;
    logic [63:0] s2_sum_next;
    logic [63:0] out_time_next;
    logic        out_en;
    logic        s2_en;
    logic        s1_en;

    // stage enables
    assign out_en = !out_valid_reg || res_ready;
    assign s2_en  = !s2_valid_reg || out_en;
    assign s1_en  = !s1_valid_reg || s2_en;
    assign pop    = entry_valid && s1_en;

    // stage 1: partial products of base, low and high halves, and delay product
    assign mult       = entry.is_t3 ? res_cfg.sync_period_ps : {16'b0, res_cfg.tick_res_ps};
    assign s1_lo_next = {32'b0, entry.base[31:0]} * {32'b0, mult};
    assign s1_hi_next = entry.base[63:32] * mult;
    assign s1_dt_next = {16'b0, entry.dtime} * {15'b0, res_cfg.delay_res_ps};

    // stage 2: low product plus delay product
    assign s2_sum_next = s1_lo_reg + {33'b0, s1_dt_reg};

    // output: fold in the high partial product
    assign out_time_next = {s2_sum_reg[63:32] + s2_hi_reg, s2_sum_reg[31:0]};

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= entry_valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (out_en)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_lo_reg   <= s1_lo_next;
            s1_hi_reg   <= s1_hi_next;
            s1_dt_reg   <= s1_dt_next;
            s1_chan_reg <= entry.chan;
        end
        if (s2_en)
        begin
            s2_sum_reg  <= s2_sum_next;
            s2_hi_reg   <= s1_hi_reg;
            s2_chan_reg <= s1_chan_reg;
        end
        if (out_en)
        begin
            out_time_reg <= out_time_next;
            out_chan_reg <= s2_chan_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_time  = $signed(out_time_reg);
    assign res_chan  = out_chan_reg;

endmodule

>>> hw/rtl/tttr_record_decoder.sv
// top level of the time-tag record decoder
//
//  channel   signals                                   direction
//  record    record_valid, record_ready, record_word    in
//  result    result_valid, result_ready, abs_time_ps,   out
//            channel
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  in
//
// one record per cycle while record_ready is high; a result leaves through these registers
// in order: queue write, partial products, low sum, high fold into the output register
// reset clears the overflow offset and loads the default format and resolutions
// a stalled result fills the three back stages, then the four-entry queue;
// record_ready falls only when that queue is full
// overflow records and dropped codes take one beat and give no result
`include "tttr_record_decoder_defines.svh"

module tttr_record_decoder #(
    parameter int OFFSET_WIDTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           record_valid,
    output logic                           record_ready,
    input  logic [31:0]                    record_word,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic signed [63:0]             abs_time_ps,
    output logic [7:0]                     channel,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tttr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    logic [2:0]            record_format_reg;
    logic [15:0]           tick_res_reg;
    logic [15:0]           delay_res_reg;
    logic [31:0]           sync_period_reg;
    tttr_pkg::res_cfg_t    res_cfg;
    tttr_pkg::entry_t      wr_entry;
    tttr_pkg::entry_t      rd_entry;
    tttr_pkg::front_stat_t f_stat;
    tttr_pkg::queue_stat_t q_stat;
    logic                  q_pop;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_format_reg <= tttr_pkg::FMT_PH_T2;
            tick_res_reg      <= 16'd1;
            delay_res_reg     <= 16'd1;
            sync_period_reg   <= 32'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tttr_pkg::CFG_RECORD_FORMAT:  record_format_reg <= cfg_data[2:0];
                tttr_pkg::CFG_TICK_RES_PS:    tick_res_reg      <= cfg_data[15:0];
                tttr_pkg::CFG_DELAY_RES_PS:   delay_res_reg     <= cfg_data[15:0];
                tttr_pkg::CFG_SYNC_PERIOD_PS: sync_period_reg   <= cfg_data;
                default:                      record_format_reg <= record_format_reg;
            endcase
        end
    end

    assign res_cfg.tick_res_ps    = tick_res_reg;
    assign res_cfg.delay_res_ps   = delay_res_reg;
    assign res_cfg.sync_period_ps = sync_period_reg;

    // decode front
    tttr_front #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .fmt       (record_format_reg),
        .rec_valid (record_valid),
        .rec_word  (record_word),
        .q_stat    (q_stat),
        .rec_ready (record_ready),
        .entry     (wr_entry),
        .stat      (f_stat)
    );

    // event queue
    tttr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_stat.push),
        .wr_entry (wr_entry),
        .pop      (q_pop),
        .rd_entry (rd_entry),
        .stat     (q_stat)
    );

    // time arithmetic back
    tttr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_cfg     (res_cfg),
        .entry_valid (!q_stat.empty),
        .entry       (rd_entry),
        .pop         (q_pop),
        .res_valid   (result_valid),
        .res_ready   (result_ready),
        .res_time    (abs_time_ps),
        .res_chan    (channel)
    );

    // checks
    `TTTR_ASSERT_IMPLIES(a_push_not_full, clk, rst_n,
        f_stat.push, !q_stat.full, "queue push while full")
    `TTTR_ASSERT_IMPLIES(a_pop_not_empty, clk, rst_n,
        q_pop, !q_stat.empty, "queue pop while empty")
    `TTTR_ASSERT_ALWAYS(a_push_wrap_excl, clk, rst_n,
        !(f_stat.push && f_stat.wrap), "overflow beat queued")
    `TTTR_ASSERT_NEXT(a_count_up, clk, rst_n,
        f_stat.push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1,
        "queue count missed a push")

endmodule

>>> dv/tb_tttr_record_decoder.sv
// self-checking testbench for the time-tag record decoder
`timescale 1ns / 1ps

module tb_tttr_record_decoder;
    import tttr_pkg::*;

    localparam int OFFSET_WIDTH = 64;
    localparam logic [63:0] OFS_MASK = {64{1'b1}} >> (64 - OFFSET_WIDTH);
    localparam int DRAIN_CYCLES = 16;
    localparam int RUN_LIMIT = 400000;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_RECORDS = 145;
    localparam int MAX_REPORTS = 10;

    // one decoded event: absolute time and channel
    typedef struct packed {
        logic [63:0] ps;
        logic [7:0]  chan;
    } decoded_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 record_valid = 1'b0;
    logic                 record_ready;
    logic [31:0]          record_word = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic signed [63:0]   abs_time_ps;
    logic [7:0]           channel;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    // register copies and overflow offset kept by the predictor
    logic [2:0]  fmt_reg = 3'd0;
    logic [15:0] tick_ps = 16'd1;
    logic [15:0] delay_ps = 16'd1;
    logic [31:0] sync_ps = 32'd1;
    logic [63:0] overflow_ofs = 64'd0;

    logic [31:0] record_q[$];
    decoded_t    decoded_q[$];

    int          err_count = 0;
    int          cycle_count = 0;
    int          hold_cycles = 0;
    int          stall_cycles = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    bit          quiet_tail = 1'b0;

    tttr_record_decoder #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .record_valid(record_valid),
        .record_ready(record_ready),
        .record_word(record_word),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .abs_time_ps(abs_time_ps),
        .channel(channel),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("tb_tttr_record_decoder failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic void add_overflow(input logic [63:0] amt);
        overflow_ofs = (overflow_ofs + amt) & OFS_MASK;
    endfunction

    function automatic void push_t2(input logic [63:0] tag, input logic [7:0] chan);
        decoded_t ev;
        ev.ps = (overflow_ofs + tag) * {48'd0, tick_ps};
        ev.chan = chan;
        decoded_q.push_back(ev);
    endfunction

    function automatic void push_t3(input logic [63:0] nsync, input logic [63:0] dtime,
                                    input logic [7:0] chan);
        decoded_t ev;
        ev.ps = (overflow_ofs + nsync) * {32'd0, sync_ps} + dtime * {48'd0, delay_ps};
        ev.chan = chan;
        decoded_q.push_back(ev);
    endfunction

    // decode one accepted record: update the offset, queue any event it gives
    function automatic void decode_record(input logic [31:0] w);
        logic [63:0] tag;
        logic [63:0] nsync;
        logic [63:0] dtime;
        logic [3:0]  ph_ch;
        logic [5:0]  hh_ch;
        ph_ch = w[31:28];
        hh_ch = w[30:25];
        case (fmt_reg)
            FMT_PH_T2:
            begin
                tag = {36'd0, w[27:0]};
                if (ph_ch == PH_CH_SPECIAL)
                begin
                    // marker bits zero mean overflow; markers keep the full tag
                    if (w[3:0] == 4'd0)
                        add_overflow(64'(WRAP_PH_T2));
                    else
                        push_t2(tag, MARK_BASE + {4'd0, w[3:0]});
                end
                else if (ph_ch <= PH_T2_MAX_CHAN)
                    push_t2(tag, {4'd0, ph_ch});
            end
            FMT_PH_T3:
            begin
                nsync = {48'd0, w[15:0]};
                dtime = {52'd0, w[27:16]};
                if (ph_ch == PH_CH_SPECIAL)
                begin
                    if (w[27:16] == 12'd0)
                        add_overflow(64'(WRAP_PH_T3));
                    else
                        push_t3(nsync, 64'd0, MARK_BASE + w[23:16]);
                end
                else
                    push_t3(nsync, dtime, {4'd0, ph_ch});
            end
            FMT_HH_T2_V1, FMT_T2_V2:
            begin
                tag = {39'd0, w[24:0]};
                if (w[31])
                begin
                    if (hh_ch == HH_CH_WRAP)
                    begin
                        if (fmt_reg == FMT_HH_T2_V1)
                            add_overflow(64'(WRAP_HH_T2_V1));
                        else if (tag == 64'd0)
                            add_overflow(64'(WRAP_HH_T2_V2));
                        else
                            add_overflow(64'(WRAP_HH_T2_V2) * tag);
                    end
                    else if (hh_ch >= 6'd1 && hh_ch <= HH_MARK_MAX)
                        push_t2(tag, MARK_BASE + {2'd0, hh_ch});
                    else if (hh_ch == 6'd0)
                        push_t2(tag, 8'd0);
                end
                else
                    push_t2(tag, {2'd0, hh_ch} + 8'd1);
            end
            FMT_HH_T3_V1, FMT_T3_V2:
            begin
                nsync = {54'd0, w[9:0]};
                dtime = {49'd0, w[24:10]};
                if (w[31])
                begin
                    if (hh_ch == HH_CH_WRAP)
                    begin
                        if (nsync == 64'd0 || fmt_reg == FMT_HH_T3_V1)
                            add_overflow(64'(WRAP_HH_T3));
                        else
                            add_overflow(64'(WRAP_HH_T3) * nsync);
                    end
                    else if (hh_ch >= 6'd1 && hh_ch <= HH_MARK_MAX)
                        push_t3(nsync, 64'd0, MARK_BASE + {2'd0, hh_ch});
                end
                else
                    push_t3(nsync, dtime, {2'd0, hh_ch});
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // record driver
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
            record_valid <= 1'b0;
        else
        begin
            if (record_valid && record_ready)
                decode_record(record_word);
            // load the next beat once the current one is gone
            if (!record_valid || record_ready)
            begin
                if (hold_cycles > 0)
                begin
                    hold_cycles--;
                    record_valid <= 1'b0;
                end
                else if (record_q.size() > 0)
                begin
                    record_valid <= 1'b1;
                    record_word <= record_q.pop_front();
                    if (!quiet_tail && $urandom_range(99) < gap_pct)
                        hold_cycles = $urandom_range(1, 4);
                end
                else
                    record_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        decoded_t ev;
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("unexpected result: time %h chan %0d", abs_time_ps, channel);
                end
                else
                begin
                    ev = decoded_q.pop_front();
                    if (abs_time_ps !== ev.ps || channel !== ev.chan)
                    begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("mismatch: time exp %h got %h, chan exp %0d got %0d",
                                     ev.ps, abs_time_ps, ev.chan, channel);
                    end
                end
            end
            // stall bursts on the result side
            if (stall_cycles > 0)
            begin
                stall_cycles--;
                result_ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(99) < stall_pct)
            begin
                stall_cycles = $urandom_range(0, 3);
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    // register write; the copy follows the block's masking
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_RECORD_FORMAT:  fmt_reg = val[2:0];
            CFG_TICK_RES_PS:    tick_ps = val[15:0];
            CFG_DELAY_RES_PS:   delay_ps = val[15:0];
            CFG_SYNC_PERIOD_PS: sync_ps = val;
            default: ;
        endcase
    endtask

    // wait until all records are in and every event is out, then let the pipe drain
    task automatic settle();
        while (record_q.size() != 0 || record_valid || decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_res16();
        case ($urandom_range(3))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly well-formed records of the given layout, some raw noise
    function automatic logic [31:0] make_record(input logic [2:0] fmt);
        int unsigned kind;
        logic [31:0] w;
        kind = $urandom_range(99);
        w = $urandom;
        case (fmt)
            FMT_PH_T2:
            begin
                if (kind < 55)
                    w[31:28] = 4'($urandom_range(0, 4));
                else if (kind < 72)
                begin
                    w[31:28] = PH_CH_SPECIAL;
                    w[3:0] = 4'($urandom_range(1, 15));
                end
                else if (kind < 88)
                begin
                    w[31:28] = PH_CH_SPECIAL;
                    w[3:0] = 4'd0;
                end
            end
            FMT_PH_T3:
            begin
                if (kind < 60)
                    w[31:28] = 4'($urandom_range(0, 14));
                else if (kind < 78)
                begin
                    w[31:28] = PH_CH_SPECIAL;
                    if (w[27:16] == 12'd0)
                        w[16] = 1'b1;
                end
                else if (kind < 92)
                begin
                    w[31:28] = PH_CH_SPECIAL;
                    w[27:16] = 12'd0;
                end
            end
            FMT_HH_T2_V1, FMT_T2_V2, FMT_HH_T3_V1, FMT_T3_V2:
            begin
                if (kind < 50)
                    w[31] = 1'b0;
                else if (kind < 65)
                begin
                    w[31] = 1'b1;
                    w[30:25] = 6'($urandom_range(1, 15));
                end
                else if (kind < 73)
                begin
                    w[31] = 1'b1;
                    w[30:25] = 6'd0;
                end
                else if (kind < 88)
                begin
                    // overflow, often with a tiny or zero count
                    w[31] = 1'b1;
                    w[30:25] = HH_CH_WRAP;
                    if (kind < 80)
                    begin
                        w[24:0] = 25'($urandom_range(0, 3));
                        w[9:0] = 10'($urandom_range(0, 3));
                    end
                end
                else if (kind < 94)
                begin
                    w[31] = 1'b1;
                    w[30:25] = 6'($urandom_range(16, 62));
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    initial
    begin
        logic [2:0]  ph_fmt;
        logic [15:0] ph_tick;
        logic [15:0] ph_delay;
        logic [31:0] ph_sync;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // PH T2 at reset settings: extremes, dropped channel, overflow, marker
        record_q.push_back(32'h0000_0000);
        record_q.push_back(32'h4FFF_FFFF);
        record_q.push_back(32'h5000_0001);
        record_q.push_back(32'hF000_0000);
        record_q.push_back(32'hFFFF_FFFF);
        record_q.push_back(32'h3123_4567);
        settle();

        // PH T3 with maximal resolutions: overflow, marker with wrapped channel
        set_reg(CFG_TICK_RES_PS, 32'h0000_FFFF);
        set_reg(CFG_DELAY_RES_PS, 32'hFFFF_FFFF);
        set_reg(CFG_SYNC_PERIOD_PS, 32'hFFFF_FFFF);
        set_reg(CFG_RECORD_FORMAT, {29'd0, FMT_PH_T3});
        record_q.push_back(32'h0000_0000);
        record_q.push_back(32'hEFFF_FFFF);
        record_q.push_back(32'hF000_FFFF);
        record_q.push_back(32'hFFFF_0001);
        record_q.push_back(32'h5123_8000);
        settle();

        // HH T2 v1: top channel, overflow, sync, marker, dropped special
        set_reg(CFG_TICK_RES_PS, 32'd3);
        set_reg(CFG_RECORD_FORMAT, {29'd0, FMT_HH_T2_V1});
        record_q.push_back(32'h7FFF_FFFF);
        record_q.push_back(32'hFE00_0000);
        record_q.push_back(32'h8000_1234);
        record_q.push_back(32'h9E00_0005);
        record_q.push_back(32'hA000_0000);
        settle();

        // T2 v2: overflow with zero and maximal count
        set_reg(CFG_RECORD_FORMAT, {29'd0, FMT_T2_V2});
        record_q.push_back(32'hFE00_0000);
        record_q.push_back(32'hFFFF_FFFF);
        record_q.push_back(32'h0000_0001);
        settle();

        // HH T3 v1: overflow ignores count, special zero gives nothing
        set_reg(CFG_SYNC_PERIOD_PS, 32'h1234_5678);
        set_reg(CFG_DELAY_RES_PS, 32'd7);
        set_reg(CFG_RECORD_FORMAT, {29'd0, FMT_HH_T3_V1});
        record_q.push_back(32'hFE00_03FF);
        record_q.push_back(32'h8000_0123);
        record_q.push_back(32'h7FFF_FFFF);
        record_q.push_back(32'h8200_0400);
        settle();

        // T3 v2: overflow with zero and maximal count
        set_reg(CFG_RECORD_FORMAT, {29'd0, FMT_T3_V2});
        record_q.push_back(32'hFE00_0000);
        record_q.push_back(32'hFE00_03FF);
        record_q.push_back(32'h0000_0000);
        settle();

        // unknown formats give nothing; writes past the register list are ignored
        set_reg(CFG_RECORD_FORMAT, 32'd6);
        record_q.push_back(32'h0123_4567);
        settle();
        set_reg(CFG_RECORD_FORMAT, 32'd7);
        record_q.push_back(32'hFFFF_FFFF);
        settle();
        set_reg(4'hF, 32'hFFFF_FFFF);
        set_reg(4'h4, 32'h0000_0000);
        set_reg(CFG_RECORD_FORMAT, {29'd0, FMT_PH_T2});
        record_q.push_back(32'h1000_0010);
        settle();

        // random phases over all layouts, resolution extremes included
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            ph_fmt = 3'(ph % 6);
            if (ph == 0)
            begin
                ph_tick = 16'd0;
                ph_delay = 16'd0;
                ph_sync = 32'd0;
            end
            else if (ph == 1)
            begin
                ph_tick = 16'hFFFF;
                ph_delay = 16'hFFFF;
                ph_sync = 32'hFFFF_FFFF;
            end
            else
            begin
                ph_tick = pick_res16();
                ph_delay = pick_res16();
                case ($urandom_range(3))
                    0: ph_sync = 32'd1;
                    1: ph_sync = 32'hFFFF_FFFF;
                    default: ph_sync = $urandom;
                endcase
            end
            set_reg(CFG_TICK_RES_PS, {16'($urandom), ph_tick});
            set_reg(CFG_DELAY_RES_PS, {16'($urandom), ph_delay});
            set_reg(CFG_SYNC_PERIOD_PS, ph_sync);
            set_reg(CFG_RECORD_FORMAT, {29'($urandom), ph_fmt});
            set_reg(4'($urandom_range(4, 15)), $urandom);

            gap_pct = 15 * $urandom_range(0, 3);
            stall_pct = 15 * $urandom_range(0, 3);
            quiet_tail = (ph == RAND_PHASES - 1);
            for (int i = 0; i < PHASE_RECORDS; i++)
                record_q.push_back(make_record(ph_fmt));
            settle();
        end

        // leftover events count as failures
        err_count += decoded_q.size();
        if (err_count == 0)
            $display("tb_tttr_record_decoder passed");
        else
            $display("tb_tttr_record_decoder failed");
        $finish;
    end

endmodule
